// File: rtl/core/hbsn_pkg.sv
// Shared types and constants for the HDLC bit-stuffing NRZI line packer.
// No dependencies; imported by hbsn_line_coder and hdlc_bit_stuff_nrzi_packer.
package hbsn_pkg;

   // Request kinds carried on req_tuser[1:0]; code 3 is unused and ignored.
   typedef enum logic [1:0] {
      FUNC_DATA  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_END   = 2'd2
   } func_type;

   // A zero is stuffed after this many ones in a row.
   localparam logic [2:0] RUN_LIMIT = 3'd5;

   // Widest line burst of one data byte: eight data bits plus two stuffed zeros.
   localparam int LINE_W = 10;

   // Line bits of one data byte, oldest in bit 0, with the coder state after it.
   typedef struct packed {
      logic [LINE_W-1:0] line;
      logic [3:0]        nbits;
      logic              level;
      logic [2:0]        run;
   } line_code_type;

   // One result as it travels on the result channel.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
      logic [9:0] byte_count;
      logic       truncated;
   } rsp_item_type;

endpackage

// File: rtl/core/hdlc_bit_stuff_nrzi_packer.sv
// HDLC bit-stuffing NRZI line packer: top level with request register,
// single-pass packing logic and a two-entry result register.
// Depends on hbsn_pkg and hbsn_line_coder.
// A request waits in the request register until the result register can take it.
// Throughput while rsp_tready holds: one request per cycle when it yields one result;
// one completing two bytes stalls the next; the result register drains one per cycle.
// Reset: synchronous, active high; clears the frame state and empties both registers.
module hdlc_bit_stuff_nrzi_packer #(
   parameter int MAX_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [2:0]  req_tuser,   // [1:0] func, [2] stuff_enable
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [17:8] byte_count, [23:18] zero
   output logic [1:0]  rsp_tuser,   // [0] byte_valid, [1] truncated
   output logic        rsp_tlast    // last result of this request
);
   import hbsn_pkg::*;

   localparam int CNT_W = $clog2(MAX_BYTES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

   // Request register
   logic       req_valid_ff;
   logic [1:0] req_func_ff;
   logic [7:0] req_data_ff;
   logic       req_stuff_ff;

   // Frame state; the open byte keeps its oldest bit in bit 0
   logic [6:0]       open_ff,    open_in;
   logic [2:0]       pending_ff, pending_in;
   logic [2:0]       run_ff,     run_in;
   logic             level_ff,   level_in;
   logic [CNT_W-1:0] cnt_ff,     cnt_in;
   logic             ovf_ff,     ovf_in;

   // Result register: current result and a held second one
   rsp_item_type rsp_ff,  second_ff;
   logic         rsp_valid_ff, second_valid_ff;

   line_code_type code;
   logic [4:0]    total;
   logic [16:0]   stream;
   logic [1:0]    nbytes;
   logic          full0, full1, full2;
   logic [CNT_W-1:0] cnt_p1, cnt_p2;
   logic [7:0]    byte0, byte1;
   logic          advance;
   rsp_item_type  item0, item1;

   function automatic logic [9:0] count10(input logic [CNT_W-1:0] c);
      logic [CNT_W+9:0] ext;
      ext = {10'b0, c};
      return ext[9:0];
   endfunction

   hbsn_line_coder u_coder (
      .stuff_enable (req_stuff_ff),
      .data_byte    (req_data_ff),
      .level_in     (level_ff),
      .run_in       (run_ff),
      .code         (code)
   );

   // Line bits of this byte behind the open bits of the byte being filled
   assign total  = {2'b0, pending_ff} + {1'b0, code.nbits};
   assign stream = {10'b0, open_ff} | ({7'b0, code.line} << pending_ff);
   assign full0  = cnt_ff >= MAX_CNT;
   assign cnt_p1 = cnt_ff + CNT_W'(1);
   assign cnt_p2 = cnt_ff + CNT_W'(2);
   assign full1  = ({1'b0, cnt_ff} + (CNT_W+1)'(1)) >= {1'b0, MAX_CNT};
   assign full2  = ({1'b0, cnt_ff} + (CNT_W+1)'(2)) >= {1'b0, MAX_CNT};

   always_comb begin
      open_in    = open_ff;
      pending_in = pending_ff;
      run_in     = run_ff;
      level_in   = level_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      nbytes     = 2'd0;
      byte0      = stream[7:0];
      byte1      = stream[15:8];
      case (func_type'(req_func_ff))
         FUNC_DATA: begin
            level_in = code.level;
            run_in   = code.run;
            if (full0) begin
               // frame full: drop every line bit
               ovf_in = 1'b1;
            end else if (total >= 5'd8 && full1) begin
               // room for one byte only: drop whatever follows it
               nbytes     = 2'd1;
               ovf_in     = ovf_ff | (total != 5'd8);
               open_in    = '0;
               pending_in = '0;
            end else if (total >= 5'd16) begin
               nbytes = 2'd2;
               if (full2) begin
                  // second byte fills the frame: drop the bit behind it
                  ovf_in     = ovf_ff | (total != 5'd16);
                  open_in    = '0;
                  pending_in = '0;
               end else begin
                  open_in    = {6'b0, stream[16]};
                  pending_in = 3'(total - 5'd16);
               end
            end else if (total >= 5'd8) begin
               nbytes     = 2'd1;
               open_in    = stream[14:8];
               pending_in = 3'(total - 5'd8);
            end else begin
               open_in    = stream[6:0];
               pending_in = 3'(total);
            end
         end
         FUNC_START: begin
            open_in    = '0;
            pending_in = '0;
            run_in     = '0;
            level_in   = 1'b0;
            cnt_in     = '0;
            ovf_in     = 1'b0;
         end
         FUNC_END: begin
            // close the open byte with zero line bits, or drop it when full
            byte0 = {1'b0, open_ff};
            if (pending_ff != 3'd0) begin
               if (full0) begin
                  ovf_in = 1'b1;
               end else begin
                  nbytes = 2'd1;
               end
            end
            open_in    = '0;
            pending_in = '0;
         end
         default: begin
         end
      endcase
      if (nbytes == 2'd2) begin
         cnt_in = cnt_p2;
      end else if (nbytes == 2'd1) begin
         cnt_in = cnt_p1;
      end
   end

   always_comb begin
      item0.out_byte   = (nbytes == 2'd0) ? 8'd0 : byte0;
      item0.byte_valid = nbytes != 2'd0;
      item0.last       = nbytes != 2'd2;
      item0.byte_count = (nbytes == 2'd0) ? count10(cnt_in) : count10(cnt_p1);
      item0.truncated  = ovf_in;
      item1.out_byte   = byte1;
      item1.byte_valid = 1'b1;
      item1.last       = 1'b1;
      item1.byte_count = count10(cnt_p2);
      item1.truncated  = ovf_in;
   end

   // Advance the request into the result register once the last held result leaves
   assign advance    = req_valid_ff &&
                       (!rsp_valid_ff || (rsp_tready && !second_valid_ff));
   assign req_tready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         second_valid_ff <= 1'b0;
         open_ff         <= '0;
         pending_ff      <= '0;
         run_ff          <= '0;
         level_ff        <= 1'b0;
         cnt_ff          <= '0;
         ovf_ff          <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff    <= 1'b1;
            second_valid_ff <= nbytes == 2'd2;
            open_ff         <= open_in;
            pending_ff      <= pending_in;
            run_ff          <= run_in;
            level_ff        <= level_in;
            cnt_ff          <= cnt_in;
            ovf_ff          <= ovf_in;
         end else if (rsp_valid_ff && rsp_tready) begin
            // hand over the held second result, or go empty
            rsp_valid_ff    <= second_valid_ff;
            second_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         req_func_ff  <= req_tuser[1:0];
         req_data_ff  <= req_tdata;
         req_stuff_ff <= req_tuser[2];
      end
      if (advance) begin
         rsp_ff    <= item0;
         second_ff <= item1;
      end else if (rsp_valid_ff && rsp_tready && second_valid_ff) begin
         rsp_ff <= second_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.byte_count, rsp_ff.out_byte};
   assign rsp_tuser  = {rsp_ff.truncated, rsp_ff.byte_valid};
   assign rsp_tlast  = rsp_ff.last;

   // A held second result always sits behind a valid current one
   assert property (@(posedge clock) disable iff (reset)
      second_valid_ff |-> rsp_valid_ff)
      else $error("second result held without a current result");

   // The current result is never marked last while a second one waits
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && second_valid_ff) |-> !rsp_ff.last)
      else $error("last flag set ahead of a held second result");

   // The frame byte count never passes the limit
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("byte count beyond limit");

   // Open bits can only exist while the frame still has room
   assert property (@(posedge clock) disable iff (reset)
      (pending_ff != 3'd0) |-> (cnt_ff < MAX_CNT))
      else $error("open bits held in a full frame");

endmodule

// File: rtl/core/hbsn_line_coder.sv
// Bit stuffing and NRZI coding of one data byte, LSB first, in one pass.
// Depends on hbsn_pkg.
module hbsn_line_coder (
   input  logic                  stuff_enable,
   input  logic [7:0]            data_byte,
   input  logic                  level_in,
   input  logic [2:0]            run_in,
   output hbsn_pkg::line_code_type code
);
   import hbsn_pkg::*;

   always_comb begin
      logic       lvl;
      logic [2:0] run;
      logic [3:0] n;
      lvl  = level_in;
      run  = run_in;
      n    = 4'd0;
      code = '0;
      for (int i = 0; i < 8; i++) begin
         // a zero toggles the line, a one holds it
         if (!data_byte[i]) begin
            lvl = ~lvl;
         end
         code.line[n] = lvl;
         n = n + 4'd1;
         if (stuff_enable) begin
            run = data_byte[i] ? run + 3'd1 : 3'd0;
            if (run >= RUN_LIMIT) begin
               // stuffed zero right after the fifth one
               lvl = ~lvl;
               code.line[n] = lvl;
               n = n + 4'd1;
               run = 3'd0;
            end
         end
      end
      code.nbits = n;
      code.level = lvl;
      code.run   = run;
   end

endmodule

// File: sim/tb_hdlc_bit_stuff_nrzi_packer.sv
// Self-checking bench for hdlc_bit_stuff_nrzi_packer: directed and random frame requests,
// a bit-stuffing NRZI packing predictor and an in-order scoreboard on the result stream.
// Depends on hbsn_pkg and the packer RTL; needs nothing else.
module tb_hdlc_bit_stuff_nrzi_packer;
   import hbsn_pkg::*;

   localparam int MAX_BYTES   = 512;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RAND_REQS   = 720;    // random requests, the long overflow frame included
   localparam int CALM_FROM   = 300;    // cycle window with no idling on either side
   localparam int CALM_TO     = 700;
   localparam int TAIL_CYCLES = 10;     // hold-off after the last expected result
   localparam int REPORT_MAX  = 20;     // mismatch lines printed before going quiet

   // Unused request kind: the block must ignore it.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data;
      logic       stuff;
   } frame_req_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] data_byte
   logic [2:0]  req_tuser  = '0;   // [1:0] func, [2] stuff_enable
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [7:0] out_byte, [17:8] byte_count, [23:18] zero
   logic [1:0]  rsp_tuser;         // [0] byte_valid, [1] truncated
   logic        rsp_tlast;

   // Predicted packer state; declaration values are the reset state.
   logic [7:0]  acc_bits    = '0;  // open output byte, newest line bit in bit 7
   logic [3:0]  acc_count   = '0;  // line bits held in the open byte
   logic [2:0]  ones_seen   = '0;  // run of ones among stuffed data bits
   logic        line_lvl    = 1'b0;
   logic [9:0]  frame_bytes = '0;
   logic        dropped     = 1'b0;

   frame_req_type req_backlog[$];     // requests not yet presented
   frame_req_type req_on_bus;         // request currently held on the input channel
   rsp_item_type  line_bytes_due[$];  // results predicted but not yet received
   rsp_item_type  item_bytes[$];      // bytes completed by the request being packed

   int  cycle_cnt  = 0;
   int  mismatches = 0;
   int  reqs_sent  = 0;
   int  rsps_seen  = 0;
   int  bytes_seen = 0;
   int  trunc_seen = 0;
   logic calm;

   hdlc_bit_stuff_nrzi_packer #(
      .MAX_BYTES (MAX_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

   // ---------------------------------------------------------------- predictor

   // Close one output byte and note it against the current request.
   function automatic void bank_byte(input logic [7:0] b);
      rsp_item_type r;
      frame_bytes  = frame_bytes + 10'd1;
      r            = '0;
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      r.byte_count = frame_bytes;
      item_bytes.push_back(r);
   endfunction

   // Shift one line bit into the open byte; drop it once the frame is full.
   function automatic void shift_line_bit(input logic b);
      if (frame_bytes >= MAX_BYTES) begin
         dropped = 1'b1;
      end else begin
         acc_bits  = {b, acc_bits[7:1]};
         acc_count = acc_count + 4'd1;
         if (acc_count == 4'd8) begin
            acc_count = '0;
            bank_byte(acc_bits);
            acc_bits = '0;
         end
      end
   endfunction

   // Advance the predicted state by one accepted request and queue its results.
   function automatic void pack_request(input frame_req_type rq);
      logic         bit_in;
      rsp_item_type r;
      int           i;
      int           k;
      item_bytes.delete();
      case (rq.func)
         FUNC_DATA: begin
            // Send LSB first; a zero toggles the line, five ones in a row get a stuffed zero.
            for (i = 0; i < 8; i++) begin
               bit_in = rq.data[i];
               if (!bit_in)
                  line_lvl = ~line_lvl;
               shift_line_bit(line_lvl);
               if (rq.stuff) begin
                  ones_seen = bit_in ? ones_seen + 3'd1 : 3'd0;
                  if (ones_seen >= RUN_LIMIT) begin
                     line_lvl = ~line_lvl;
                     shift_line_bit(line_lvl);
                     ones_seen = '0;
                  end
               end
            end
         end
         FUNC_START: begin
            acc_bits    = '0;
            acc_count   = '0;
            ones_seen   = '0;
            line_lvl    = 1'b0;
            frame_bytes = '0;
            dropped     = 1'b0;
         end
         FUNC_END: begin
            // Pad the open byte with raw zero line bits; level and run are kept.
            if (acc_count != 4'd0) begin
               if (frame_bytes >= MAX_BYTES)
                  dropped = 1'b1;
               else
                  bank_byte(acc_bits >> (4'd8 - acc_count));
            end
            acc_count = '0;
            acc_bits  = '0;
         end
         default: ;
      endcase

      if (item_bytes.size() == 0) begin
         r            = '0;
         r.last       = 1'b1;
         r.byte_count = frame_bytes;
         r.truncated  = dropped;
         line_bytes_due.push_back(r);
      end else begin
         for (k = 0; k < item_bytes.size(); k++) begin
            r           = item_bytes[k];
            r.last      = (k == item_bytes.size() - 1);
            r.truncated = dropped;
            line_bytes_due.push_back(r);
         end
      end
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic void queue_req(input logic [1:0] f, input logic [7:0] d, input logic s);
      frame_req_type rq;
      rq.func  = f;
      rq.data  = d;
      rq.stuff = s;
      req_backlog.push_back(rq);
   endfunction

   // Favor runs of ones so stuffing fires often; plain random bytes otherwise.
   function automatic logic [7:0] rand_payload();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30)
         return 8'hFF;
      else if (pick < 60)
         return 8'($urandom | $urandom);
      else
         return 8'($urandom);
   endfunction

   // ---------------------------------------------------------------- driver

   // Predict on acceptance, then present the next request unless idling.
   // Valid is only touched when the channel is free, so a held request never drops.
   always @(posedge clock) begin : req_drive
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pack_request(req_on_bus);
            reqs_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
               req_on_bus = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= req_on_bus.data;
               req_tuser  <= {req_on_bus.stuff, req_on_bus.func};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // Compare each accepted result with the oldest prediction; stall at random.
   always @(posedge clock) begin : rsp_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte   = rsp_tdata[7:0];
            got.byte_valid = rsp_tuser[0];
            got.last       = rsp_tlast;
            got.byte_count = rsp_tdata[17:8];
            got.truncated  = rsp_tuser[1];
            rsps_seen++;
            if (got.byte_valid === 1'b1)
               bytes_seen++;
            if (got.truncated === 1'b1)
               trunc_seen++;
            if (line_bytes_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: unexpected result byte=%h valid=%b last=%b count=%0d trunc=%b",
                           $time, got.out_byte, got.byte_valid, got.last, got.byte_count,
                           got.truncated);
            end else begin
               want = line_bytes_due.pop_front();
               if (got !== want || rsp_tdata[23:18] !== 6'd0) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display({"%0t: mismatch expected byte=%h valid=%b last=%b count=%0d trunc=%b",
                               " actual byte=%h valid=%b last=%b count=%0d trunc=%b pad=%h"},
                              $time, want.out_byte, want.byte_valid, want.last,
                              want.byte_count, want.truncated, got.out_byte, got.byte_valid,
                              got.last, got.byte_count, got.truncated, rsp_tdata[23:18]);
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 10);
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin : watchdog
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("%0t: run stalled, %0d results still due", $time, line_bytes_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      int   n;
      int   i;
      int   len;
      logic flood_done;

      // Directed: field extremes, stuffing on and off, padding, ignored code, bare frames.
      queue_req(FUNC_START,  8'h00, 1'b0);
      queue_req(FUNC_DATA,   8'h00, 1'b1);   // all zeros: line toggles every bit
      queue_req(FUNC_DATA,   8'hFF, 1'b1);   // five ones then a stuffed zero
      queue_req(FUNC_DATA,   8'hFF, 1'b1);   // run carries across the byte boundary
      queue_req(FUNC_DATA,   8'hFF, 1'b0);   // no stuffing, run left alone
      queue_req(FUNC_DATA,   8'h7E, 1'b0);   // flag pattern
      queue_req(FUNC_DATA,   8'h1F, 1'b1);
      queue_req(FUNC_DATA,   8'hF8, 1'b1);
      queue_req(FUNC_DATA,   8'h01, 1'b1);
      queue_req(FUNC_DATA,   8'h80, 1'b1);
      queue_req(FUNC_DATA,   8'h55, 1'b0);
      queue_req(FUNC_DATA,   8'hAA, 1'b1);
      queue_req(FUNC_END,    8'hFF, 1'b1);   // pad the open byte
      queue_req(FUNC_END,    8'h00, 1'b0);   // nothing pending
      queue_req(FUNC_UNUSED, 8'hFF, 1'b1);   // ignored, one empty result
      queue_req(FUNC_DATA,   8'h3C, 1'b1);   // data with no fresh start
      queue_req(FUNC_START,  8'hFF, 1'b1);
      queue_req(FUNC_END,    8'h00, 1'b0);   // empty frame
      queue_req(FUNC_DATA,   8'hFE, 1'b1);
      queue_req(FUNC_DATA,   8'hFF, 1'b1);
      queue_req(FUNC_END,    8'h00, 1'b1);
      queue_req(FUNC_START,  8'h00, 1'b0);

      // Random: mostly well-formed frames, some loose noise, and one frame long
      // enough to hit the byte limit and raise truncation.
      n          = 0;
      flood_done = 1'b0;
      while (n < RAND_REQS) begin
         if (!flood_done && n >= 60) begin
            flood_done = 1'b1;
            queue_req(FUNC_START, 8'($urandom), 1'($urandom));
            for (i = 0; i < 560; i++)
               queue_req(FUNC_DATA, rand_payload(), $urandom_range(99) < 95);
            queue_req(FUNC_END, 8'($urandom), 1'($urandom));
            queue_req(FUNC_DATA, rand_payload(), 1'b1);   // dropped while full
            queue_req(FUNC_END, 8'($urandom), 1'($urandom));
            n += 564;
         end else if ($urandom_range(99) < 85) begin
            len = $urandom_range(1, 24);
            queue_req(FUNC_START, 8'($urandom), 1'($urandom));
            for (i = 0; i < len; i++)
               queue_req(FUNC_DATA, rand_payload(), $urandom_range(99) < 85);
            queue_req(FUNC_END, 8'($urandom), 1'($urandom));
            n += len + 2;
         end else begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
               queue_req(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
            n += len;
         end
      end

      // Hold reset, then release it for good.
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request is taken and every predicted result has come back.
      while (req_backlog.size() != 0 || req_tvalid || line_bytes_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (line_bytes_due.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, line_bytes_due.size());
         mismatches++;
      end

      $display("Covered %0d frame requests and %0d results, %0d of them packed bytes;",
               reqs_sent, rsps_seen, bytes_seen);
      $display("%0d results carried the truncation flag, %0d mismatches.",
               trunc_seen, mismatches);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
